// ===== hw/rtl/sha_pkg.sv =====
// Shared types and constants of the SHA-256 byte stream hasher.
package sha_pkg;

   localparam int WORD_W     = 32;
   localparam int HASH_WORDS = 8;
   localparam int BLK_WORDS  = 16;
   localparam int ROUNDS     = 64;

   localparam logic [5:0] FILL_LAST     = 6'd63;
   localparam logic [5:0] FILL_LEN_POS  = 6'd56;
   localparam logic [5:0] ROUND_LAST    = 6'd63;
   localparam logic [2:0] WORD_IDX_LAST = 3'd7;
   localparam logic [7:0] PAD_MARK_BYTE = 8'h80;

   localparam logic [WORD_W-1:0] ROUND_K [ROUNDS] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [HASH_WORDS-1:0][WORD_W-1:0] INIT_HASH = {
      32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
      32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
   };

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD_MARK,
      ST_PAD_ZERO,
      ST_PAD_LEN,
      ST_ROUND,
      ST_ADD,
      ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      BYTE_MSG,
      BYTE_MARK,
      BYTE_ZERO,
      BYTE_LEN
   } byte_sel_type;

   typedef struct packed {
      logic         shift_en;
      byte_sel_type byte_sel;
      logic         load_v;
      logic         round_en;
      logic         add_h;
      logic         restart;
      logic [2:0]   word_sel;
   } cmd_type;

   typedef struct packed {
      logic fill_last;
      logic fill_len;
      logic round_last;
   } sts_type;

endpackage

// ===== hw/rtl/sha_req_if.sv =====
// Request channel: one message byte and an end-of-message flag per word.
interface sha_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] msg_byte;
   logic       byte_present;
   logic       end_of_message;

   modport source (output valid, output msg_byte, output byte_present,
                   output end_of_message, input ready);
   modport sink   (input valid, input msg_byte, input byte_present,
                   input end_of_message, output ready);
endinterface

// ===== hw/rtl/sha_rsp_if.sv =====
// Response channel: one digest word with its index per word.
interface sha_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        last_word;

   modport source (output valid, output digest_word, output word_index,
                   output last_word, input ready);
   modport sink   (input valid, input digest_word, input word_index,
                   input last_word, output ready);
endinterface

// ===== hw/rtl/sha256_byte_stream_hasher.sv =====
// SHA-256 byte stream hasher top level: controller, datapath and handshake channels.
// Byte words are taken one per cycle while idle; the 64th byte of a block starts a compression
// of 64 rounds of the single round unit, then the hash update. End of message: pad bytes one
// per cycle between compressions, pausing in the zero-pad state before the length field, then
// one or two compressions and eight digest words, one per cycle while the sink is ready. No word
// is taken meanwhile; synchronous reset loads the initial hash and clears the counts.
module sha256_byte_stream_hasher
   import sha_pkg::*;
(
   input logic        clock,
   input logic        reset,
   sha_req_if.sink    req_ch,
   sha_rsp_if.source  rsp_ch
);

   cmd_type cmd;
   sts_type sts;

   sha_ctrl u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_ch.valid),
      .req_byte_present   (req_ch.byte_present),
      .req_end_of_message (req_ch.end_of_message),
      .req_ready          (req_ch.ready),
      .rsp_valid          (rsp_ch.valid),
      .rsp_ready          (rsp_ch.ready),
      .rsp_word_index     (rsp_ch.word_index),
      .rsp_last_word      (rsp_ch.last_word),
      .sts                (sts),
      .cmd                (cmd)
   );

   sha_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .msg_byte    (req_ch.msg_byte),
      .sts         (sts),
      .digest_word (rsp_ch.digest_word)
   );

   // The block never takes a word while a digest is being delivered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> !req_ch.ready)
      else $error("request accepted during digest output");

   // Digest words leave in order without gaps once the sink takes one.
   assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.ready && !rsp_ch.last_word |=>
         rsp_ch.valid && (rsp_ch.word_index == $past(rsp_ch.word_index) + 3'd1))
      else $error("digest word sequence broken");

   // After the final digest word the block is ready for the next message.
   assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.ready && rsp_ch.last_word |=> req_ch.ready && !rsp_ch.valid)
      else $error("block did not return to idle after the digest");

endmodule

// ===== hw/rtl/sha_dpath.sv =====
// SHA-256 datapath: block shift register, message schedule, round logic and hash state.
module sha_dpath
   import sha_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   input  logic [7:0]        msg_byte,
   output sts_type           sts,
   output logic [WORD_W-1:0] digest_word
);

   function automatic logic [WORD_W-1:0] rotr(input logic [WORD_W-1:0] x, input int n);
      rotr = (x >> n) | (x << (WORD_W - n));
   endfunction

   function automatic logic [WORD_W-1:0] big_sig0(input logic [WORD_W-1:0] x);
      big_sig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic logic [WORD_W-1:0] big_sig1(input logic [WORD_W-1:0] x);
      big_sig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

   function automatic logic [WORD_W-1:0] small_sig0(input logic [WORD_W-1:0] x);
      small_sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic logic [WORD_W-1:0] small_sig1(input logic [WORD_W-1:0] x);
      small_sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

   // Word 15 is the oldest: it takes the first byte of a block and is W[t] during rounds.
   logic [BLK_WORDS-1:0][WORD_W-1:0]  blk_ff, blk_in;
   logic [HASH_WORDS-1:0][WORD_W-1:0] h_ff, h_in;
   logic [HASH_WORDS-1:0][WORD_W-1:0] v_ff, v_in;
   logic [5:0]                        round_ff, round_in;
   logic [5:0]                        fill_ff, fill_in;
   logic [63:0]                       bits_ff, bits_in;

   logic [7:0]        byte_mux;
   logic [WORD_W-1:0] w_new;
   logic [WORD_W-1:0] t1;
   logic [WORD_W-1:0] t2;
   logic [WORD_W-1:0] choose;
   logic [WORD_W-1:0] major;

   always_comb begin
      case (cmd.byte_sel)
         BYTE_MSG:  byte_mux = msg_byte;
         BYTE_MARK: byte_mux = PAD_MARK_BYTE;
         BYTE_ZERO: byte_mux = 8'h00;
         BYTE_LEN:  byte_mux = bits_ff[63:56];
         default:   byte_mux = 8'h00;
      endcase
   end

   // Schedule window holds W[t] .. W[t+15]; the new word is W[t+16].
   assign w_new = small_sig1(blk_ff[1]) + blk_ff[6] + small_sig0(blk_ff[14]) + blk_ff[15];

   assign choose = (v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]);
   assign major  = (v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]);
   assign t1     = v_ff[7] + big_sig1(v_ff[4]) + choose + ROUND_K[round_ff] + blk_ff[15];
   assign t2     = big_sig0(v_ff[0]) + major;

   always_comb begin
      blk_in   = blk_ff;
      h_in     = h_ff;
      v_in     = v_ff;
      round_in = round_ff;
      fill_in  = fill_ff;
      bits_in  = bits_ff;

      if (cmd.shift_en) begin
         blk_in  = {blk_ff[15][23:0], blk_ff[14:0], byte_mux};
         fill_in = fill_ff + 6'd1;
         if (cmd.byte_sel == BYTE_MSG) begin
            bits_in = bits_ff + 64'd8;
         end else if (cmd.byte_sel == BYTE_LEN) begin
            bits_in = {bits_ff[55:0], 8'h00};
         end
      end else if (cmd.round_en) begin
         blk_in = {blk_ff[14:0], w_new};
      end

      if (cmd.load_v) begin
         v_in     = h_ff;
         round_in = '0;
      end else if (cmd.round_en) begin
         v_in     = {v_ff[6:4], v_ff[3] + t1, v_ff[2:0], t1 + t2};
         round_in = round_ff + 6'd1;
      end

      if (cmd.add_h) begin
         for (int i = 0; i < HASH_WORDS; i++) begin
            h_in[i] = h_ff[i] + v_ff[i];
         end
      end

      if (cmd.restart) begin
         h_in    = INIT_HASH;
         fill_in = '0;
         bits_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      blk_ff <= blk_in;
      v_ff   <= v_in;
      if (reset) begin
         h_ff     <= INIT_HASH;
         round_ff <= '0;
         fill_ff  <= '0;
         bits_ff  <= '0;
      end else begin
         h_ff     <= h_in;
         round_ff <= round_in;
         fill_ff  <= fill_in;
         bits_ff  <= bits_in;
      end
   end

   assign sts.fill_last  = (fill_ff == FILL_LAST);
   assign sts.fill_len   = (fill_ff == FILL_LEN_POS);
   assign sts.round_last = (round_ff == ROUND_LAST);
   assign digest_word    = h_ff[cmd.word_sel];

endmodule

// ===== hw/rtl/sha_ctrl.sv =====
// SHA-256 controller: sequences byte intake, padding, compression and digest output.
module sha_ctrl
   import sha_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_byte_present,
   input  logic       req_end_of_message,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_word_index,
   output logic       rsp_last_word,
   input  sts_type    sts,
   output cmd_type    cmd
);

   state_type  state_ff, state_in;
   state_type  ret_ff, ret_in;
   logic [2:0] idx_ff, idx_in;

   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      idx_in   = idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_byte_present && sts.fill_last) begin
                  state_in = ST_ROUND;
                  ret_in   = req_end_of_message ? ST_PAD_MARK : ST_IDLE;
               end else if (req_end_of_message) begin
                  state_in = ST_PAD_MARK;
               end
            end
         end
         ST_PAD_MARK: begin
            if (sts.fill_last) begin
               state_in = ST_ROUND;
               ret_in   = ST_PAD_ZERO;
            end else begin
               state_in = ST_PAD_ZERO;
            end
         end
         ST_PAD_ZERO: begin
            if (sts.fill_len) begin
               state_in = ST_PAD_LEN;
            end else if (sts.fill_last) begin
               state_in = ST_ROUND;
               ret_in   = ST_PAD_ZERO;
            end
         end
         ST_PAD_LEN: begin
            if (sts.fill_last) begin
               state_in = ST_ROUND;
               ret_in   = ST_OUT;
            end
         end
         ST_ROUND: begin
            if (sts.round_last) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            state_in = ret_ff;
         end
         ST_OUT: begin
            if (rsp_ready) begin
               idx_in = idx_ff + 3'd1;
               if (idx_ff == WORD_IDX_LAST) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd          = '0;
      cmd.word_sel = idx_ff;
      req_ready    = 1'b0;
      rsp_valid    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid && req_byte_present) begin
               cmd.shift_en = 1'b1;
               cmd.byte_sel = BYTE_MSG;
               cmd.load_v   = sts.fill_last;
            end
         end
         ST_PAD_MARK: begin
            cmd.shift_en = 1'b1;
            cmd.byte_sel = BYTE_MARK;
            cmd.load_v   = sts.fill_last;
         end
         ST_PAD_ZERO: begin
            if (!sts.fill_len) begin
               cmd.shift_en = 1'b1;
               cmd.byte_sel = BYTE_ZERO;
               cmd.load_v   = sts.fill_last;
            end
         end
         ST_PAD_LEN: begin
            cmd.shift_en = 1'b1;
            cmd.byte_sel = BYTE_LEN;
            cmd.load_v   = sts.fill_last;
         end
         ST_ROUND: begin
            cmd.round_en = 1'b1;
         end
         ST_ADD: begin
            cmd.add_h = 1'b1;
         end
         ST_OUT: begin
            rsp_valid   = 1'b1;
            cmd.restart = rsp_ready && (idx_ff == WORD_IDX_LAST);
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   assign rsp_word_index = idx_ff;
   assign rsp_last_word  = (idx_ff == WORD_IDX_LAST);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ret_ff   <= ST_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         idx_ff   <= idx_in;
      end
   end

endmodule
